### rtl/core/sound_module_frame_receiver_defines.svh
// Assertion macros for the frame receiver RTL
// No dependencies; included by modules that carry concurrent checks
`ifndef SOUND_MODULE_FRAME_RECEIVER_DEFINES_SVH
`define SOUND_MODULE_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SMFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SMFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/smfr_pkg.sv
// Shared types and constants for the sound module frame receiver
// No dependencies; imported by every module of the block
package smfr_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ADDR,
    PH_LEN,
    PH_DATA
  } smfr_phase_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_HEAD    = 2'd0;
  localparam logic [1:0] REG_ADDR    = 2'd1;
  localparam logic [1:0] REG_MIN_LEN = 2'd2;

  // reset values of the registers
  localparam logic [7:0] HEAD_RESET    = 8'd126;
  localparam logic [7:0] ADDR_RESET    = 8'd255;
  localparam logic [7:0] MIN_LEN_RESET = 8'd6;

  // smallest usable length, keeps address and length inside the sum
  localparam logic [7:0] MIN_LEN_FLOOR = 8'd2;

  // position of the first payload byte
  localparam logic [8:0] DATA_START = 9'd3;

  // configuration values seen by the parser
  typedef struct packed {
    logic [7:0] head_value;
    logic [7:0] address_value;
    logic [7:0] min_length;
  } smfr_cfg_t;

  // one result item
  typedef struct packed {
    logic [7:0] byte_out;
    logic       in_frame;
    logic [8:0] position;
    logic       frame_end;
    logic       checksum_ok;
  } smfr_result_t;

endpackage

### rtl/core/smfr_cfg_regs.sv
// APB-style register file for the frame receiver settings
// Depends on smfr_pkg for register indexes, reset values and smfr_cfg_t
module smfr_cfg_regs
  import smfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output smfr_cfg_t   cfg
);

  logic [7:0] head_r;
  logic [7:0] addr_r;
  logic [7:0] min_len_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= HEAD_RESET;
      addr_r    <= ADDR_RESET;
      min_len_r <= MIN_LEN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HEAD:    head_r    <= pwdata[7:0];
        REG_ADDR:    addr_r    <= pwdata[7:0];
        REG_MIN_LEN: min_len_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_HEAD:    prdata = {24'd0, head_r};
      REG_ADDR:    prdata = {24'd0, addr_r};
      REG_MIN_LEN: prdata = {24'd0, min_len_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg.head_value    = head_r;
  assign cfg.address_value = addr_r;
  assign cfg.min_length    = min_len_r;

endmodule

### rtl/core/smfr_parser.sv
// Frame hunting state machine with running checksum, one byte per step
// Depends on smfr_pkg and the assertion macros in the defines header
`include "sound_module_frame_receiver_defines.svh"

module smfr_parser
  import smfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  logic [7:0]   byte_in,
  input  smfr_cfg_t    cfg,
  output smfr_result_t res
);

  smfr_phase_t phase_r, phase_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  chk_hi_r, chk_hi_nxt;

  logic [7:0]  minimum;
  logic [9:0]  idx_ext;
  logic [9:0]  len_ext;
  logic [15:0] byte_ext;

  assign minimum  = (cfg.min_length < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : cfg.min_length;
  assign idx_ext  = {1'b0, idx_r};
  assign len_ext  = {2'b00, len_r};
  assign byte_ext = {8'd0, byte_in};

  // state register, advances once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      len_r    <= 8'd0;
      idx_r    <= 9'd0;
      sum_r    <= 16'd0;
      chk_hi_r <= 8'd0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      sum_r    <= sum_nxt;
      chk_hi_r <= chk_hi_nxt;
    end
  end

  // next state and result for the byte at the input register
  always_comb begin
    phase_nxt       = phase_r;
    len_nxt         = len_r;
    idx_nxt         = idx_r;
    sum_nxt         = sum_r;
    chk_hi_nxt      = chk_hi_r;
    res.byte_out    = byte_in;
    res.in_frame    = 1'b0;
    res.position    = 9'd0;
    res.frame_end   = 1'b0;
    res.checksum_ok = 1'b0;
    case (phase_r)
      PH_HUNT: begin
        if (byte_in == cfg.head_value) begin
          res.in_frame = 1'b1;
          sum_nxt      = 16'd0;
          phase_nxt    = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (byte_in == cfg.address_value) begin
          res.in_frame = 1'b1;
          res.position = 9'd1;
          sum_nxt      = byte_ext;
          phase_nxt    = PH_LEN;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (byte_in >= minimum) begin
          res.in_frame = 1'b1;
          res.position = 9'd2;
          len_nxt      = byte_in;
          sum_nxt      = sum_r + byte_ext;
          idx_nxt      = DATA_START;
          phase_nxt    = PH_DATA;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_DATA: begin
        res.in_frame = 1'b1;
        res.position = idx_r;
        // payload is summed, then the checksum word, high byte first
        if (idx_ext <= len_ext) begin
          sum_nxt = sum_r + byte_ext;
        end else if (idx_ext == len_ext + 10'd1) begin
          chk_hi_nxt = byte_in;
        end else if (idx_ext == len_ext + 10'd2) begin
          sum_nxt = sum_r + {chk_hi_r, byte_in};
        end
        // end byte closes the frame, its value is not checked
        if (idx_ext >= len_ext + 10'd3) begin
          res.frame_end   = 1'b1;
          res.checksum_ok = (sum_r == 16'd0);
          phase_nxt       = PH_HUNT;
        end else begin
          idx_nxt = idx_r + 9'd1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // checks
  `SMFR_ASSERT_NOW(a_end_in_frame, clk, rst_n, res.frame_end, res.in_frame, "frame end outside a frame")
  `SMFR_ASSERT_NOW(a_reject_pos, clk, rst_n, !res.in_frame, res.position == 9'd0 && !res.checksum_ok, "rejected byte carries frame fields")
  `SMFR_ASSERT_NOW(a_idx_range, clk, rst_n, phase_r == PH_DATA, idx_r >= DATA_START && {1'b0, idx_r} <= {2'b00, len_r} + 10'd3, "data index out of frame")
  `SMFR_ASSERT_NOW(a_len_floor, clk, rst_n, phase_r == PH_DATA, len_r >= MIN_LEN_FLOOR, "latched length below floor")
  `SMFR_ASSERT_NEXT(a_end_hunt, clk, rst_n, step_en && res.frame_end, phase_r == PH_HUNT, "no return to hunting after frame end")

endmodule

### rtl/core/smfr_out_reg.sv
// Result register driving the output stream channel
// Depends on smfr_pkg for smfr_result_t
module smfr_out_reg
  import smfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  logic         load_valid,
  input  smfr_result_t load_res,
  output logic         out_valid,
  output smfr_result_t out_res
);

  logic         valid_r;
  smfr_result_t res_r;

  // valid flag, control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### rtl/core/sound_module_frame_receiver.sv
// Sound module frame receiver: byte stream in, tagged byte stream out
// Depends on smfr_pkg, smfr_cfg_regs, smfr_parser and smfr_out_reg
//
// Usage:
//   in_*   : received serial bytes, one per transfer, in_tdata[7:0]
//   out_*  : exactly one result transfer per input byte, in input order;
//            tdata carries the byte, its frame position and the checksum
//            flag, tuser marks bytes inside a frame, tlast the frame end
//   cfg_*  : head byte, address byte and minimum length at 0x0, 0x4, 0x8;
//            write only while no byte is in flight
// Path: a byte accepted on in_* passes the input register, then the result
//   register, before it is offered on out_*.
// Throughput: one byte per cycle unless a stall holds the result register;
//   the per-byte parser update between the registers is combinational.
// Reset (rst_n low, synchronous): both stages empty, parser hunting for a
//   head byte, registers back to 0x7E, 0xFF and 6.
// Stall: with out_tready low the result register holds its transfer; the
//   input register still takes one more byte, then in_tready drops until
//   the result is taken. Parser state moves only when a byte advances.
module sound_module_frame_receiver
  import smfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] byte_out, [16:8] position, [17] checksum_ok
  output logic        out_tuser,  // [0] in_frame
  output logic        out_tlast,  // frame_end
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  smfr_cfg_t    cfg;
  smfr_result_t step_res;
  smfr_result_t out_res;
  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         advance;
  logic         step_en;

  // pipeline moves when the result register is free or being emptied
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign step_en   = s1_valid_r && advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  smfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  smfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .byte_in (s1_byte_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  smfr_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .load_valid (s1_valid_r),
    .load_res   (step_res),
    .out_valid  (out_tvalid),
    .out_res    (out_res)
  );

  // output packing
  assign out_tdata = {6'd0, out_res.checksum_ok, out_res.position, out_res.byte_out};
  assign out_tuser = out_res.in_frame;
  assign out_tlast = out_res.frame_end;

endmodule
